// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the checker of this block.
// Each macro samples on the rising edge of clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property outside reset.
`define PTROT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check a property at every edge, reset included.
`define PTROT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/ptrot_pkg.sv =====
package ptrot_pkg;

  // Default and upper bound of the micro-rotation count
  localparam int ROTATION_STEPS_DEF = 16;
  localparam int MAX_STEPS = 32;

  // Widths: offset, rotation datapath, gain product
  localparam int OW = 33;
  localparam int CW = 36;
  localparam int PW = CW + 32;

  // Degrees to turns: floor(u / 45) by reciprocal, u = angle + 2^31
  localparam logic [32:0] DEG_RECIP = 33'd6108397933;
  localparam int DEG_RECIP_SHIFT = 38;
  localparam int DEG_Q_W = 27;
  localparam logic [31:0] DEG_DIV = 32'd45;
  // 2^31 = 45 * DEG_BIAS_Q + DEG_BIAS_R
  localparam logic [31:0] DEG_BIAS_Q = 32'd47721858;
  localparam logic [5:0] DEG_BIAS_R = 6'd38;
  localparam logic [5:0] DEG_BIAS_RC = 6'd7;

  // Radians to turns: round(2^32 / (2*pi)), applied to Q16.16
  localparam logic signed [31:0] RAD_SCALE = 32'sd683565276;

  // Angle unit code
  localparam logic MODE_DEG = 1'b1;

  // Quarter-turn pre-rotation
  typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

  // Arctangent of 2^-i in turn units (2^32 per turn)
  localparam logic [31:0] ATAN_TURNS [MAX_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] pivot_x;
    logic signed [31:0] pivot_y;
    logic signed [31:0] angle;
    logic               mode;
  } ptrot_in_t;

  typedef struct packed {
    logic signed [31:0] rotated_x;
    logic signed [31:0] rotated_y;
  } ptrot_out_t;

  // Vector travelling along the rotation cells
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [31:0]   z;
    logic signed [31:0]   pivot_x;
    logic signed [31:0]   pivot_y;
  } ptrot_vec_t;

  // Nearest of r * 8192 / 45 for a remainder r below 45
  function automatic logic [12:0] deg_frac(input logic [5:0] r);
    logic [12:0] base;
    logic [12:0] corr;
    base = 13'(r) * 13'd182;
    corr = (r >= 6'd34) ? 13'd2 : ((r >= 6'd12) ? 13'd1 : 13'd0);
    return base + corr;
  endfunction

  // Integer square root, one result bit per pass
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bt;
    rem = v;
    res = '0;
    for (int b = 31; b >= 0; b--) begin
      bt = 64'd1 << (2 * b);
      if (rem >= res + bt) begin
        rem = rem - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
    end
    return res;
  endfunction

  // Square root of the Q60 product of (1 + 4^-i) over the steps used
  function automatic logic [63:0] gain_root(input int n);
    logic [63:0] p;
    logic [63:0] r;
    p = 64'd1 << 60;
    for (int i = 0; i < MAX_STEPS; i++) begin
      if (i < n) begin
        p = p + (p >> (2 * i));
      end
    end
    r = isqrt64(p);
    return (r == 64'd0) ? 64'd1 : r;
  endfunction

  // Clamp a wide signed value to the 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[PW-1:31];
    hi_zeros = ~|v[PW-1:31];
    if (hi_ones || hi_zeros) begin
      return v[31:0];
    end else if (v[PW-1]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7FFF_FFFF;
    end
  endfunction

endpackage

// ===== rtl/core/point_rotation_about_pivot.sv =====
// Point rotation about a pivot, signed Q16.16.
// Input: present an item on in_item with start high; it is taken at the
// clock edge where start is high and busy is low. busy is high only in the
// cycle after a reset edge, so one item can be taken in every cycle.
// Output: each item gives one rotated point on out_item, shown for exactly
// one cycle with out_valid high, in the order the items were taken.
// Pipeline: three front stages (angle products, turn count, quarter turn),
// one register per micro-rotation cell, then gain product and rounding/clamp.
// Throughput: one item per cycle, set by the row of rotation cells, each
// of which holds one item and hands it to the next cell every cycle.
// Reset: synchronous, active low; it empties the pipeline, so no result
// leaves for an item taken before reset.
// The receiver cannot stall: out_valid is not held off, every result is
// shown once and must be taken in its cycle.
module point_rotation_about_pivot #(
  parameter int ROTATION_STEPS = ptrot_pkg::ROTATION_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  ptrot_pkg::ptrot_in_t  in_item,
  output logic                  out_valid,
  output ptrot_pkg::ptrot_out_t out_item
);
  import ptrot_pkg::*;

  localparam int STEPS_C = (ROTATION_STEPS > MAX_STEPS) ? MAX_STEPS :
                           ((ROTATION_STEPS < 1) ? 1 : ROTATION_STEPS);
  localparam int LATENCY = STEPS_C + 5;

  logic       busy_r;
  logic       accept;
  logic       cv_valid [0:STEPS_C];
  ptrot_vec_t cv       [0:STEPS_C];

  // Hold off items only in the cycle after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  ptrot_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_item   (in_item),
    .vec_valid (cv_valid[0]),
    .vec       (cv[0])
  );

  // Row of micro-rotation cells
  for (genvar i = 0; i < STEPS_C; i++) begin : g_cell
    ptrot_cell #(
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (cv_valid[i]),
      .in_vec    (cv[i]),
      .out_valid (cv_valid[i+1]),
      .out_vec   (cv[i+1])
    );
  end

  ptrot_gain #(
    .STEPS (STEPS_C)
  ) u_gain (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cv_valid[STEPS_C]),
    .in_vec    (cv[STEPS_C]),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ===== rtl/core/ptrot_front.sv =====
module ptrot_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  ptrot_pkg::ptrot_in_t  in_item,
  output logic                  vec_valid,
  output ptrot_pkg::ptrot_vec_t vec
);
  import ptrot_pkg::*;

  // Stage A: offsets and the two angle products
  logic                      a_valid_r;
  logic [31:0]               a_u_r;
  logic [DEG_Q_W-1:0]        a_q_r;
  logic [47:0]               a_rad_r;
  logic                      a_mode_r;
  logic signed [OW-1:0]      a_dx_r;
  logic signed [OW-1:0]      a_dy_r;
  logic signed [31:0]        a_px_r;
  logic signed [31:0]        a_py_r;

  logic [31:0]               u;
  logic [64:0]               deg_prod;
  logic signed [63:0]        rad_prod;

  // Stage B: angle in turns
  logic                      b_valid_r;
  logic [31:0]               b_t_r;
  logic signed [OW-1:0]      b_dx_r;
  logic signed [OW-1:0]      b_dy_r;
  logic signed [31:0]        b_px_r;
  logic signed [31:0]        b_py_r;

  logic [31:0]               qd45;
  logic [5:0]                ru;
  logic [5:0]                rr;
  logic [31:0]               qq;
  logic [31:0]               t_deg;
  logic [47:0]               rad_round;
  logic [31:0]               t_nxt;

  // Stage C: quadrant turn and residual angle
  logic                      c_valid_r;
  ptrot_vec_t                c_vec_r;
  ptrot_vec_t                c_vec_nxt;
  logic [31:0]               tq;
  quad_t                     quad;
  logic signed [CW-1:0]      xe;
  logic signed [CW-1:0]      ye;

  // Offset the angle so the quotient by 45 stays unsigned
  assign u        = {~in_item.angle[31], in_item.angle[30:0]};
  assign deg_prod = 65'(u) * 65'(DEG_RECIP);
  assign rad_prod = 64'(in_item.angle) * 64'(RAD_SCALE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    a_u_r    <= u;
    a_q_r    <= deg_prod[DEG_RECIP_SHIFT +: DEG_Q_W];
    a_rad_r  <= rad_prod[47:0];
    a_mode_r <= in_item.mode;
    a_dx_r   <= OW'(in_item.point_x) - OW'(in_item.pivot_x);
    a_dy_r   <= OW'(in_item.point_y) - OW'(in_item.pivot_y);
    a_px_r   <= in_item.pivot_x;
    a_py_r   <= in_item.pivot_y;
  end

  // Remainder by 45, move the bias back and build the turn count
  always_comb begin
    qd45 = 32'(a_q_r) * DEG_DIV;
    ru   = a_u_r[5:0] - qd45[5:0];
    if (ru >= DEG_BIAS_R) begin
      rr = ru - DEG_BIAS_R;
      qq = 32'(a_q_r) - DEG_BIAS_Q;
    end else begin
      rr = ru + DEG_BIAS_RC;
      qq = 32'(a_q_r) - (DEG_BIAS_Q + 32'd1);
    end
    t_deg     = {qq[18:0], 13'b0} + 32'(deg_frac(rr));
    rad_round = a_rad_r + 48'd32768;
    t_nxt     = (a_mode_r == MODE_DEG) ? t_deg : rad_round[47:16];
  end

  always_ff @(posedge clk) begin
    b_t_r  <= t_nxt;
    b_dx_r <= a_dx_r;
    b_dy_r <= a_dy_r;
    b_px_r <= a_px_r;
    b_py_r <= a_py_r;
  end

  // Turn by whole quarters, keep the residual for the cells
  always_comb begin
    tq   = b_t_r + 32'h2000_0000;
    quad = quad_t'(tq[31:30]);
    xe   = CW'(b_dx_r);
    ye   = CW'(b_dy_r);
    c_vec_nxt.z       = signed'(b_t_r - {tq[31:30], 30'b0});
    c_vec_nxt.pivot_x = b_px_r;
    c_vec_nxt.pivot_y = b_py_r;
    case (quad)
      QUAD_1: begin
        c_vec_nxt.x = -ye;
        c_vec_nxt.y = xe;
      end
      QUAD_2: begin
        c_vec_nxt.x = -xe;
        c_vec_nxt.y = -ye;
      end
      QUAD_3: begin
        c_vec_nxt.x = ye;
        c_vec_nxt.y = -xe;
      end
      default: begin
        c_vec_nxt.x = xe;
        c_vec_nxt.y = ye;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    c_vec_r <= c_vec_nxt;
  end

  assign vec_valid = c_valid_r;
  assign vec       = c_vec_r;

endmodule

// ===== rtl/core/ptrot_cell.sv =====
module ptrot_cell #(
  parameter int IDX = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  ptrot_pkg::ptrot_vec_t in_vec,
  output logic                  out_valid,
  output ptrot_pkg::ptrot_vec_t out_vec
);
  import ptrot_pkg::*;

  localparam logic [31:0] ATAN_I = ATAN_TURNS[IDX[4:0]];

  logic                 valid_r;
  ptrot_vec_t           vec_r;
  ptrot_vec_t           vec_nxt;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;

  // One micro-rotation toward a zero residual angle
  always_comb begin
    dx = in_vec.y >>> IDX;
    dy = in_vec.x >>> IDX;
    vec_nxt = in_vec;
    if (!in_vec.z[31]) begin
      vec_nxt.x = in_vec.x - dx;
      vec_nxt.y = in_vec.y + dy;
      vec_nxt.z = in_vec.z - signed'(ATAN_I);
    end else begin
      vec_nxt.x = in_vec.x + dx;
      vec_nxt.y = in_vec.y - dy;
      vec_nxt.z = in_vec.z + signed'(ATAN_I);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    vec_r <= vec_nxt;
  end

  assign out_valid = valid_r;
  assign out_vec   = vec_r;

endmodule

// ===== rtl/core/ptrot_gain.sv =====
module ptrot_gain #(
  parameter int STEPS = ptrot_pkg::ROTATION_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  ptrot_pkg::ptrot_vec_t in_vec,
  output logic                  out_valid,
  output ptrot_pkg::ptrot_out_t out_item
);
  import ptrot_pkg::*;

  // Inverse of the rotation gain, Q30
  localparam logic [63:0] ROOT   = gain_root(STEPS);
  localparam logic [63:0] GAIN64 = (64'd1 << 60) / ROOT;
  localparam logic signed [31:0] GAIN = signed'(GAIN64[31:0]);

  logic                 m_valid_r;
  logic signed [PW-1:0] m_x_r;
  logic signed [PW-1:0] m_y_r;
  logic signed [31:0]   m_px_r;
  logic signed [31:0]   m_py_r;

  logic                 o_valid_r;
  ptrot_out_t           o_item_r;
  ptrot_out_t           o_item_nxt;
  logic signed [PW-1:0] sx;
  logic signed [PW-1:0] sy;
  logic signed [PW-1:0] fx;
  logic signed [PW-1:0] fy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      m_valid_r <= in_valid;
      o_valid_r <= m_valid_r;
    end
  end

  // Scale by the inverse gain
  always_ff @(posedge clk) begin
    m_x_r  <= PW'(in_vec.x) * PW'(GAIN);
    m_y_r  <= PW'(in_vec.y) * PW'(GAIN);
    m_px_r <= in_vec.pivot_x;
    m_py_r <= in_vec.pivot_y;
  end

  // Round back to Q16.16, add the pivot and clamp
  always_comb begin
    sx = (m_x_r + (PW'(1) <<< 29)) >>> 30;
    sy = (m_y_r + (PW'(1) <<< 29)) >>> 30;
    fx = sx + PW'(m_px_r);
    fy = sy + PW'(m_py_r);
    o_item_nxt.rotated_x = sat32(fx);
    o_item_nxt.rotated_y = sat32(fy);
  end

  always_ff @(posedge clk) begin
    o_item_r <= o_item_nxt;
  end

  assign out_valid = o_valid_r;
  assign out_item  = o_item_r;

endmodule

// ===== rtl/core/ptrot_checker.sv =====
`include "assert_macros.svh"

module ptrot_checker #(
  parameter int LATENCY = ptrot_pkg::ROTATION_STEPS_DEF + 5
) (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // Reset empties the pipeline
  `PTROT_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid, "result after reset")

  // Items are taken in every cycle once out of reset
  `PTROT_ASSERT(a_never_busy, rst_n |=> !busy, "busy outside reset")

  // Every item taken gives its result after the fixed latency
  `PTROT_ASSERT(a_result_due, (start && !busy) |-> ##LATENCY out_valid, "result missing")

  // No result without an item taken the same latency before
  `PTROT_ASSERT(a_no_extra, !(start && !busy) |-> ##LATENCY !out_valid, "result invented")

endmodule

bind point_rotation_about_pivot ptrot_checker #(
  .LATENCY (LATENCY)
) u_ptrot_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

// ===== verif/tb_point_rotation_about_pivot.sv =====
module tb_point_rotation_about_pivot;
  import ptrot_pkg::*;

  localparam int STEPS      = ROTATION_STEPS_DEF;
  localparam int USED_STEPS = (STEPS > 32) ? 32 : ((STEPS < 1) ? 1 : STEPS);
  localparam int LATENCY    = STEPS + 5;
  localparam int QUIET_MAX  = 500;
  localparam int N_RANDOM   = 2000;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] ONE     = 32'sh0001_0000;
  localparam int                 DEG1    = 65536;

  // Arctangent of 2^-i in turn units, 2^32 to the turn
  localparam logic [31:0] ARCTAN_TURN [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef struct {
    ptrot_in_t   item;
    int unsigned gap;
    bit          drain;
  } pending_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  ptrot_in_t  in_item = '0;
  logic       out_valid;
  ptrot_out_t out_item;

  pending_t    pending_items[$];
  ptrot_out_t  rotated_due[$];
  longint      gain_k;
  int unsigned gap_left = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  point_rotation_about_pivot #(.ROTATION_STEPS(STEPS)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Inverse CORDIC gain in Q30 for the steps used
  function automatic longint cordic_gain(int n);
    logic [63:0] prod;
    logic [63:0] root;
    logic [63:0] trial;
    prod = 64'd1 << 60;
    for (int i = 0; i < n; i++) begin
      prod += prod >> (2 * i);
    end
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= prod) root = trial;
    end
    if (root == 0) root = 64'd1;
    return longint'((64'd1 << 60) / root);
  endfunction

  // Convert the angle to a wrapping fraction of one turn
  function automatic logic [31:0] angle_turns(logic signed [31:0] a, logic m);
    longint      num;
    logic [63:0] scaled;
    if (m == MODE_DEG) begin
      num = (longint'(a) * 8192 + (longint'(45) <<< 44) + 22) / 45 - (longint'(1) <<< 44);
      return num[31:0];
    end
    scaled = longint'(a) * 64'sd683565276 + 64'sd32768;
    return scaled[47:16];
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > longint'(S32_MAX)) return S32_MAX;
    if (v < longint'(S32_MIN)) return S32_MIN;
    return v[31:0];
  endfunction

  // Rotate the point about the pivot: quarter turn, micro-rotations, gain
  function automatic ptrot_out_t rotate_about_pivot(ptrot_in_t it);
    longint      cx, cy, ox, oy, sx, dx, dy, z, rx, ry;
    logic [31:0] turns;
    logic [31:0] biased;
    logic [31:0] resid;
    quad_t       quad;
    ptrot_out_t  res;
    cx = it.pivot_x;
    cy = it.pivot_y;
    ox = longint'(it.point_x) - cx;
    oy = longint'(it.point_y) - cy;
    turns = angle_turns(it.angle, it.mode);
    biased = turns + 32'h2000_0000;
    quad = quad_t'(biased[31:30]);
    resid = turns - {biased[31:30], 30'b0};
    z = longint'($signed(resid));
    case (quad)
      QUAD_1: begin
        sx = ox; ox = -oy; oy = sx;
      end
      QUAD_2: begin
        ox = -ox; oy = -oy;
      end
      QUAD_3: begin
        sx = ox; ox = oy; oy = -sx;
      end
      default: ;
    endcase
    for (int i = 0; i < USED_STEPS; i++) begin
      dx = oy >>> i;
      dy = ox >>> i;
      if (z >= 0) begin
        ox -= dx; oy += dy; z -= longint'(ARCTAN_TURN[i]);
      end else begin
        ox += dx; oy -= dy; z += longint'(ARCTAN_TURN[i]);
      end
    end
    rx = (ox * gain_k + (longint'(1) <<< 29)) >>> 30;
    ry = (oy * gain_k + (longint'(1) <<< 29)) >>> 30;
    res.rotated_x = clamp32(rx + cx);
    res.rotated_y = clamp32(ry + cy);
    return res;
  endfunction

  function automatic logic signed [31:0] pick_coord();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return {{8{r[23]}}, r[23:0]};
      4, 5, 6, 7: return r;
      8:          return (r[0]) ? S32_MAX : S32_MIN;
      default:    return {{16{r[15]}}, r[15:0]};
    endcase
  endfunction

  function automatic ptrot_in_t random_item();
    ptrot_in_t it;
    it.point_x = pick_coord();
    it.point_y = pick_coord();
    it.pivot_x = pick_coord();
    it.pivot_y = pick_coord();
    it.mode = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: it.angle = $urandom;
      4, 5: begin
        it.mode = MODE_DEG;
        it.angle = int'($urandom_range(0, 1440 * DEG1)) - 720 * DEG1;
      end
      6, 7: begin
        it.mode = ~MODE_DEG;
        it.angle = int'($urandom_range(0, 14 * DEG1)) - 7 * DEG1;
      end
      8: begin
        it.mode = MODE_DEG;
        it.angle = (int'($urandom_range(0, 16)) - 8) * 45 * DEG1;
      end
      default: it.angle = int'($urandom_range(0, 2000)) - 1000;
    endcase
    return it;
  endfunction

  task automatic add_item(logic signed [31:0] px, logic signed [31:0] py,
                          logic signed [31:0] cx, logic signed [31:0] cy,
                          logic signed [31:0] a, logic m, bit drain);
    pending_t p;
    p.item = '{point_x: px, point_y: py, pivot_x: cx, pivot_y: cy, angle: a, mode: m};
    p.gap = 0;
    p.drain = drain;
    pending_items.push_back(p);
  endtask

  // Fill the item queue, run the reset, then wait for the last result
  initial begin
    pending_t p;
    bit       steady;
    gain_k = cordic_gain(USED_STEPS);

    // quarter turns, half turns, wrap past a full turn
    add_item(ONE, 0, 0, 0, 0, ~MODE_DEG, 0);
    add_item(ONE, 0, 0, 0, 90 * DEG1, MODE_DEG, 0);
    add_item(ONE, 0, 0, 0, -90 * DEG1, MODE_DEG, 0);
    add_item(ONE, ONE, 0, 0, 180 * DEG1, MODE_DEG, 0);
    add_item(ONE, 0, 0, 0, 45 * DEG1, MODE_DEG, 0);
    add_item(ONE, 0, 0, 0, -45 * DEG1, MODE_DEG, 0);
    add_item(ONE, 0, 0, 0, 135 * DEG1, MODE_DEG, 0);
    add_item(ONE, 0, ONE, ONE, 360 * DEG1, MODE_DEG, 0);
    add_item(3 * ONE, -2 * ONE, ONE, ONE, 720 * DEG1, MODE_DEG, 0);
    add_item(ONE, 0, 0, 0, 102944, ~MODE_DEG, 0);
    add_item(ONE, 0, 0, 0, 205887, ~MODE_DEG, 0);
    add_item(ONE, 0, 0, 0, -205887, ~MODE_DEG, 0);
    // angle extremes in both units
    add_item(ONE, ONE, 0, 0, S32_MAX, ~MODE_DEG, 0);
    add_item(ONE, ONE, 0, 0, S32_MIN, ~MODE_DEG, 0);
    add_item(ONE, ONE, 0, 0, S32_MAX, MODE_DEG, 0);
    add_item(ONE, ONE, 0, 0, S32_MIN, MODE_DEG, 0);
    // saturation at both ends of the range
    add_item(S32_MAX, S32_MAX, S32_MIN, S32_MIN, 180 * DEG1, MODE_DEG, 0);
    add_item(S32_MIN, S32_MIN, S32_MAX, S32_MAX, 180 * DEG1, MODE_DEG, 0);
    add_item(S32_MAX, S32_MIN, S32_MIN, S32_MAX, 45 * DEG1, MODE_DEG, 0);
    add_item(S32_MIN, S32_MAX, S32_MAX, S32_MIN, -135 * DEG1, MODE_DEG, 0);
    add_item(S32_MAX, S32_MAX, S32_MAX, S32_MAX, 30 * DEG1, MODE_DEG, 0);
    add_item(S32_MIN, S32_MIN, S32_MIN, S32_MIN, 205887, ~MODE_DEG, 1);

    // random items, with stretches that run back to back
    steady = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 100 == 0) steady = ($urandom_range(0, 2) == 0);
      p.item = random_item();
      p.drain = (n % 500 == 499);
      if (steady) begin
        p.gap = 0;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:59]:  p.gap = 0;
          [60:89]: p.gap = $urandom_range(1, 3);
          [90:97]: p.gap = $urandom_range(4, 12);
          default: p.gap = $urandom_range(20, 40);
        endcase
      end
      pending_items.push_back(p);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_items.size() == 0 && rotated_due.size() == 0);
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatch_count == 0 && rotated_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Drive: present the head item, hold it until taken, then wait out the next item's gap
  always @(posedge clk) begin
    logic go;
    go = 1'b0;
    if (rst_n) begin
      if (start && !busy) begin
        rotated_due.push_back(rotate_about_pivot(in_item));
        void'(pending_items.pop_front());
        gap_left = (pending_items.size() > 0) ? pending_items[0].gap : 0;
      end
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_items.size() > 0 &&
                   !(pending_items[0].drain && rotated_due.size() > 0)) begin
        go = 1'b1;
      end
    end
    start <= go;
    if (go) in_item <= pending_items[0].item;
  end

  // Check each result against the oldest expected point
  always @(posedge clk) begin
    ptrot_out_t want;
    if (rst_n && out_valid) begin
      if (rotated_due.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result x=%0d y=%0d", out_item.rotated_x, out_item.rotated_y);
        mismatch_count++;
      end else begin
        want = rotated_due.pop_front();
        if (out_item.rotated_x !== want.rotated_x || out_item.rotated_y !== want.rotated_y) begin
          if (mismatch_count < 10)
            $display("result mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                     want.rotated_x, want.rotated_y, out_item.rotated_x, out_item.rotated_y);
          mismatch_count++;
        end
      end
    end
  end

  // Stop when nothing moves on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
